// ----- src/dss_pkg.sv -----
// Shared types and constants for the descending selection sorter.
// Used by dss_store, dss_seq and descending_selection_sort_top; no dependencies.

package dss_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 16;
	localparam int TAG_W    = 3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
	} in_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0] sorted_key;
		logic [TAG_W-1:0] sorted_tag;
		logic             end_of_set;
	} out_beat_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic             emit_load;
		logic [CNT_W-1:0] count;
	} seq_status_t;

endpackage

// ----- src/dss_store.sv -----
// Entry store of the sorter: one write port, one read port, registered read data.
// Depends on dss_pkg for the entry and request types.

module dss_store (
	input  logic              clk,
	input  dss_pkg::mem_req_t req,
	output dss_pkg::entry_t   rdata
);

	dss_pkg::entry_t mem [dss_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ----- src/dss_seq.sv -----
// Sequencer of the sorter: loads the store, runs the selection passes by
// read-compare-swap on dss_store, then drains the result beats.
// Depends on dss_pkg.

module dss_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  dss_pkg::in_beat_t    item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output dss_pkg::out_beat_t   result,
	output dss_pkg::mem_req_t    mem_req,
	input  dss_pkg::entry_t      mem_rdata,
	output dss_pkg::seq_status_t status
);

	localparam int CNT_W = dss_pkg::CNT_W;
	localparam int IDX_W = dss_pkg::IDX_W;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_SWAP1 = 6'b000100,
		ST_SWAP2 = 6'b001000,
		ST_ERD   = 6'b010000,
		ST_EDAT  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pass_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] emit_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_addr_s1;
	dss_pkg::entry_t  best_q;
	dss_pkg::entry_t  pent_q;
	logic [IDX_W-1:0] bidx_q;
	dss_pkg::out_beat_t out_q;
	logic             out_vld_q;

	logic [CNT_W-1:0] last_cnt;
	logic [CNT_W:0]   pass_plus2;
	logic             has_room;
	logic             issue;
	logic             slot_free;
	logic [CNT_W-1:0] n_new;

	assign last_cnt   = count_q - CNT_W'(1);
	assign pass_plus2 = {1'b0, pass_q} + (CNT_W + 1)'(2);
	assign has_room   = (count_q < CNT_W'(dss_pkg::CAPACITY));
	assign issue      = (state_q == ST_SCAN) && (scan_q <= last_cnt);
	assign slot_free  = !out_vld_q || !result_stall;
	assign n_new      = has_room ? (count_q + CNT_W'(1)) : count_q;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_vld_q;
	assign result       = out_q;

	assign status.emit_load = (state_q == ST_EDAT);
	assign status.count     = count_q;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				mem_req.we        = item_valid && has_room;
				mem_req.waddr     = count_q[IDX_W-1:0];
				mem_req.wdata.key = item.key;
				mem_req.wdata.tag = item.tag;
			end
			ST_SCAN: begin
				mem_req.re    = issue;
				mem_req.raddr = scan_q[IDX_W-1:0];
			end
			ST_SWAP1: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pass_q[IDX_W-1:0];
				mem_req.wdata = best_q;
			end
			ST_SWAP2: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = bidx_q;
				mem_req.wdata = pent_q;
			end
			ST_ERD: begin
				mem_req.re    = slot_free;
				mem_req.raddr = emit_q[IDX_W-1:0];
			end
			ST_EDAT: begin
				mem_req = '0;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			pass_q    <= '0;
			scan_q    <= '0;
			emit_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_EDAT) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end

			rd_vld_s1 <= issue;

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						count_q <= n_new;
						if (item.last) begin
							pass_q <= '0;
							scan_q <= '0;
							emit_q <= '0;
							if (n_new == CNT_W'(1)) begin
								state_q <= ST_ERD;
							end else if (n_new != '0) begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					// final compare of the pass lands on the last entry
					if (rd_vld_s1 && (rd_addr_s1 == last_cnt[IDX_W-1:0])) begin
						state_q <= ST_SWAP1;
					end
				end
				ST_SWAP1: begin
					state_q <= ST_SWAP2;
				end
				ST_SWAP2: begin
					pass_q <= pass_q + CNT_W'(1);
					scan_q <= pass_q + CNT_W'(1);
					emit_q <= '0;
					if (pass_plus2 >= {1'b0, count_q}) begin
						state_q <= ST_ERD;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_ERD: begin
					if (slot_free) begin
						state_q <= ST_EDAT;
					end
				end
				ST_EDAT: begin
					emit_q <= emit_q + CNT_W'(1);
					if (emit_q == last_cnt) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ERD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan datapath: first entry of the pass seeds the best, later ones win only if greater
	always_ff @(posedge clk) begin
		rd_addr_s1 <= scan_q[IDX_W-1:0];
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (rd_addr_s1 == pass_q[IDX_W-1:0]) begin
				best_q <= mem_rdata;
				pent_q <= mem_rdata;
				bidx_q <= rd_addr_s1;
			end else if (mem_rdata.key > best_q.key) begin
				best_q <= mem_rdata;
				bidx_q <= rd_addr_s1;
			end
		end
		if (state_q == ST_EDAT) begin
			out_q.sorted_key <= mem_rdata.key;
			out_q.sorted_tag <= mem_rdata.tag;
			out_q.end_of_set <= (emit_q == last_cnt);
		end
	end

endmodule

// ----- src/descending_selection_sort_top.sv -----
// Descending selection sorter: loads up to CAPACITY tagged keys, one beat per cycle,
// until a beat marked last arrives; beats beyond capacity are dropped. The set is then
// sorted in place into descending key order (ties keep the swap order of selection sort)
// and emitted, the final beat flagged with end_of_set. All entries live in one store with
// a single read port and registered read data. Each pass reads every remaining entry once,
// compares each registered read against the best so far, then writes the swap in two steps;
// n-1 passes run for n>1, and each result is read from the store and then loaded into the
// output register, waiting while a downstream stall holds that register. item_stall
// stays high from the last beat until the final result has been handed to the output
// register. Depends on dss_pkg, dss_store and dss_seq.

module descending_selection_sort_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  dss_pkg::in_beat_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output dss_pkg::out_beat_t result
);

	dss_pkg::mem_req_t    mem_req;
	dss_pkg::entry_t      mem_rdata;
	dss_pkg::seq_status_t status;

	dss_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	dss_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.status       (status)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= dss_pkg::CNT_W'(dss_pkg::CAPACITY))
		else $error("item count exceeds capacity");

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit_load |-> !result_valid)
		else $error("result register loaded while still holding a beat");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(status.emit_load))
		else $error("result valid raised without a store read");

	a_no_accept_while_sorting: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit_load |-> item_stall)
		else $error("input open while results are being drained");

endmodule
